// ===== hw/rtl/rcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcr_pkg: shared types for the rectangle connector router
// Pixel and half-pixel coordinate types, rectangle pair and route records.
// ----------------------------------------------------------------------------
`default_nettype none

package rcr_pkg;

  // Field widths
  localparam int unsigned PixW   = 16;
  localparam int unsigned CoordW = PixW + 1;
  localparam int unsigned InW    = 8 * PixW;
  localparam int unsigned SegW   = 4 * CoordW;
  localparam int unsigned OutW   = ((SegW + 7) / 8) * 8;

  typedef logic signed [PixW-1:0]   pix_t;
  typedef logic signed [CoordW-1:0] coord_t;

  // Edges, left in the lowest bits
  typedef struct packed {
    pix_t bottom;
    pix_t right;
    pix_t top;
    pix_t left;
  } rect_t;

  // Rectangle A in the lowest bits, matches the input word layout
  typedef struct packed {
    rect_t b;
    rect_t a;
  } pair_t;

  // One segment, start_x in the lowest bits
  typedef struct packed {
    coord_t ey;
    coord_t ex;
    coord_t sy;
    coord_t sx;
  } seg_t;

  // Full route for one pair: one or two segments
  typedef struct packed {
    logic ok;
    logic two;
    seg_t s0;
    seg_t s1;
  } route_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcr_route.sv =====
// ----------------------------------------------------------------------------
// rcr_route: connector route logic
// Tests the four placements of A against B in priority order and builds the
// straight or L shaped route in doubled coordinates. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_route (
  input  wire rcr_pkg::pair_t pair_i,
  output rcr_pkg::route_t     route_o
);

  // Doubled edges and edge sums (centers)
  rcr_pkg::coord_t acx, acy, bcx, bcy;
  rcr_pkg::coord_t al2, at2, ar2, ab2, bl2, bt2, br2, bb2;
  rcr_pkg::coord_t a_h, b_h, a_w, b_w;
  rcr_pkg::route_t hr0, hr1, vr0, vr1;

  function automatic rcr_pkg::coord_t dbl(rcr_pkg::pix_t p);
    return {p, 1'b0};
  endfunction

  function automatic rcr_pkg::coord_t add(rcr_pkg::pix_t p, rcr_pkg::pix_t q);
    return {p[rcr_pkg::PixW-1], p} + {q[rcr_pkg::PixW-1], q};
  endfunction

  function automatic rcr_pkg::coord_t sub(rcr_pkg::pix_t p, rcr_pkg::pix_t q);
    return {p[rcr_pkg::PixW-1], p} - {q[rcr_pkg::PixW-1], q};
  endfunction

  // Left / right placement
  function automatic rcr_pkg::route_t h_route(
    logic hit, rcr_pkg::coord_t a_near, rcr_pkg::coord_t b_near,
    rcr_pkg::coord_t cx_a, rcr_pkg::coord_t cy_a, rcr_pkg::coord_t cy_b,
    rcr_pkg::coord_t top_a, rcr_pkg::coord_t bot_a,
    logic ab_in, logic ba_in, logic a_big);
    rcr_pkg::route_t r;
    logic ab_ok, ba_ok;
    r = '0;
    ab_ok = ab_in & ~(ba_in & a_big);
    ba_ok = ba_in & ~(ab_in & ~a_big);
    if (hit) begin
      if (ab_ok) begin
        r.ok = 1'b1;
        r.s0 = '{ey: cy_a, ex: b_near, sy: cy_a, sx: a_near};
      end else if (ba_ok) begin
        r.ok = 1'b1;
        r.s0 = '{ey: cy_b, ex: a_near, sy: cy_b, sx: b_near};
      end else if (top_a >= cy_b || bot_a <= cy_b) begin
        r.ok  = 1'b1;
        r.two = 1'b1;
        r.s0  = '{ey: cy_b, ex: cx_a, sy: cy_b, sx: b_near};
        r.s1  = '{ey: (top_a >= cy_b) ? top_a : bot_a, ex: cx_a, sy: cy_b, sx: cx_a};
      end
    end
    return r;
  endfunction

  // Above / below placement
  function automatic rcr_pkg::route_t v_route(
    logic hit, rcr_pkg::coord_t a_near, rcr_pkg::coord_t b_near,
    rcr_pkg::coord_t cx_a, rcr_pkg::coord_t cy_a, rcr_pkg::coord_t cx_b,
    rcr_pkg::coord_t lft_a, rcr_pkg::coord_t rgt_a,
    logic ab_in, logic ba_in, logic a_big);
    rcr_pkg::route_t r;
    logic ab_ok, ba_ok;
    r = '0;
    ab_ok = ab_in & ~(ba_in & a_big);
    ba_ok = ba_in & ~(ab_in & ~a_big);
    if (hit) begin
      if (ab_ok) begin
        r.ok = 1'b1;
        r.s0 = '{ey: b_near, ex: cx_a, sy: a_near, sx: cx_a};
      end else if (ba_ok) begin
        r.ok = 1'b1;
        r.s0 = '{ey: a_near, ex: cx_b, sy: b_near, sx: cx_b};
      end else if (lft_a >= cx_b || rgt_a <= cx_b) begin
        r.ok  = 1'b1;
        r.two = 1'b1;
        r.s0  = '{ey: cy_a, ex: cx_b, sy: b_near, sx: cx_b};
        r.s1  = '{ey: cy_a, ex: (lft_a >= cx_b) ? lft_a : rgt_a, sy: cy_a, sx: cx_b};
      end
    end
    return r;
  endfunction

  assign acx = add(pair_i.a.left, pair_i.a.right);
  assign acy = add(pair_i.a.top, pair_i.a.bottom);
  assign bcx = add(pair_i.b.left, pair_i.b.right);
  assign bcy = add(pair_i.b.top, pair_i.b.bottom);
  assign al2 = dbl(pair_i.a.left);
  assign at2 = dbl(pair_i.a.top);
  assign ar2 = dbl(pair_i.a.right);
  assign ab2 = dbl(pair_i.a.bottom);
  assign bl2 = dbl(pair_i.b.left);
  assign bt2 = dbl(pair_i.b.top);
  assign br2 = dbl(pair_i.b.right);
  assign bb2 = dbl(pair_i.b.bottom);
  assign a_h = sub(pair_i.a.bottom, pair_i.a.top);
  assign b_h = sub(pair_i.b.bottom, pair_i.b.top);
  assign a_w = sub(pair_i.a.right, pair_i.a.left);
  assign b_w = sub(pair_i.b.right, pair_i.b.left);

  // The four candidate placements
  assign hr0 = h_route(acx >= br2, al2, br2, acx, acy, bcy, at2, ab2,
                       (acy >= bt2) && (acy <= bb2), (bcy >= at2) && (bcy <= ab2),
                       a_h > b_h);
  assign hr1 = h_route(acx <= bl2, ar2, bl2, acx, acy, bcy, at2, ab2,
                       (acy >= bt2) && (acy <= bb2), (bcy >= at2) && (bcy <= ab2),
                       a_h > b_h);
  assign vr0 = v_route(pair_i.a.bottom < pair_i.b.top, ab2, bt2, acx, acy, bcx, al2, ar2,
                       (acx >= bl2) && (acx <= br2), (bcx >= al2) && (bcx <= ar2),
                       a_w > b_w);
  assign vr1 = v_route(pair_i.a.top > pair_i.b.bottom, at2, bb2, acx, acy, bcx, al2, ar2,
                       (acx >= bl2) && (acx <= br2), (bcx >= al2) && (bcx <= ar2),
                       a_w > b_w);

  // First placement that yields a route wins; otherwise the zero segment
  always_comb begin
    if (hr0.ok) begin
      route_o = hr0;
    end else if (hr1.ok) begin
      route_o = hr1;
    end else if (vr0.ok) begin
      route_o = vr0;
    end else if (vr1.ok) begin
      route_o = vr1;
    end else begin
      route_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rect_connector_router_top.sv =====
// ----------------------------------------------------------------------------
// rect_connector_router_top: connector router between two rectangles
// Stream wrapper around the route logic with an input and a result register.
// ----------------------------------------------------------------------------
// Each input word carries rectangles A and B; the block returns the connector
// between them as one straight segment or two segments of an L, in half-pixel
// coordinates, with tlast on the final segment and tuser set when a route was
// found (an unroutable pair gives one all-zero segment with tuser low). The
// route is computed combinationally between the input register and the result
// register. Both segments of a pair leave through the single result channel,
// so a pair that yields an L holds the result register until both of its
// segments have left; a new pair is taken while the previous result waits.
`default_nettype none

module rect_connector_router_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
  input  wire logic [rcr_pkg::InW-1:0]  s_axis_tdata_i,
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // start_x, start_y, end_x, end_y, zero fill
  output logic [rcr_pkg::OutW-1:0]      m_axis_tdata_o,
  // connected
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i
);

  rcr_pkg::pair_t  in_q;
  logic            in_valid_q;
  rcr_pkg::route_t route;
  rcr_pkg::route_t res_q;
  logic            res_valid_q, idx_q;
  logic            out_take, out_last, res_free, move, in_free;
  rcr_pkg::seg_t   seg;

  // Handshake bookkeeping
  assign out_last = ~res_q.two | idx_q;
  assign out_take = res_valid_q & m_axis_tready_i;
  assign res_free = ~res_valid_q | (out_take & out_last);
  assign move     = in_valid_q & res_free;
  assign in_free  = ~in_valid_q | move;

  assign s_axis_tready_o = in_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid_i) begin
      in_q <= rcr_pkg::pair_t'(s_axis_tdata_i);
    end
  end

  rcr_route u_route (
    .pair_i  (in_q),
    .route_o (route)
  );

  // Result register and segment index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= move;
      idx_q       <= 1'b0;
    end else if (out_take) begin
      idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= route;
    end
  end

  // Output word
  assign seg             = idx_q ? res_q.s1 : res_q.s0;
  assign m_axis_tdata_o  = {{(rcr_pkg::OutW - rcr_pkg::SegW){1'b0}}, seg};
  assign m_axis_tuser_o  = res_q.ok;
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tvalid_o = res_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rcr_checker.sv =====
// ----------------------------------------------------------------------------
// rcr_checker: port-level checks for the rectangle connector router
// Watches the input and result streams and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic [rcr_pkg::InW-1:0]  s_axis_tdata_i,
  input wire logic                     s_axis_tvalid_i,
  input wire logic                     s_axis_tready_o,
  input wire logic [rcr_pkg::OutW-1:0] m_axis_tdata_o,
  input wire logic                     m_axis_tuser_o,
  input wire logic                     m_axis_tlast_o,
  input wire logic                     m_axis_tvalid_o,
  input wire logic                     m_axis_tready_i
);

  localparam int unsigned HalfW = 2 * rcr_pkg::CoordW;

  // Stalled input word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i))
    else $error("stalled input changed");

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Unroutable pair: a single all-zero segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("fallback segment malformed");

  // Second leg of an L follows right after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && m_axis_tuser_o)
    else $error("second segment missing");

  // The L is continuous: second start equals first end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tdata_o[HalfW-1:0] == $past(m_axis_tdata_o[2*HalfW-1:HalfW]))
    else $error("L route not continuous");

endmodule

bind rect_connector_router_top rcr_checker u_rcr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire
